// ===== src/mse_pkg.sv =====
// Package for the merge sort engine: sizes, the link type that carries a
// value between neighbouring cells, and the signed compare.
// No dependencies.
package mse_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 32;
  localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

  typedef logic [VALUE_BITS-1:0] val_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  // One value travelling along the chain, with its valid flag
  typedef struct packed {
    logic vld;
    val_t val;
  } mse_link_t;

  // Strict signed less-than; equal values leave the earlier one in place
  function automatic logic val_lt(input val_t a, input val_t b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ===== src/mse_if.sv =====
// Handshake channels of the merge sort engine: input items and results.
// Depends on mse_pkg.
interface mse_in_if
  import mse_pkg::*;
  ();
  logic valid;
  logic ready;
  val_t value;
  logic final_item;

  modport source (output valid, output value, output final_item, input ready);
  modport sink   (input valid, input value, input final_item, output ready);
endinterface

interface mse_out_if
  import mse_pkg::*;
  ();
  logic valid;
  logic ready;
  val_t sorted_value;
  logic final_result;
  logic overflow;

  modport source (output valid, output sorted_value, output final_result,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input final_result,
                  input overflow, output ready);
endinterface

// ===== src/mse_cell.sv =====
// One cell of the systolic insertion chain: holds one value, keeps the
// smaller of held and arriving, hands the larger on to the right, and in
// the emit phase takes the right neighbour's value. Depends on mse_pkg.
module mse_cell
  import mse_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      shift_en,   // emit phase: take the right neighbour's value
  input  mse_link_t from_left,  // value arriving from the left
  input  mse_link_t from_right, // right neighbour's held value
  output mse_link_t held,
  output mse_link_t to_right
);

  logic held_vld_r, held_vld_nxt;
  val_t held_val_r, held_val_nxt;
  logic pass_vld_r, pass_vld_nxt;
  val_t pass_val_r, pass_val_nxt;

  // Insert / shift decision
  always_comb begin
    held_vld_nxt = held_vld_r;
    held_val_nxt = held_val_r;
    pass_vld_nxt = 1'b0;
    pass_val_nxt = pass_val_r;
    if (shift_en) begin
      held_vld_nxt = from_right.vld;
      held_val_nxt = from_right.val;
    end else if (from_left.vld) begin
      if (!held_vld_r) begin
        held_vld_nxt = 1'b1;
        held_val_nxt = from_left.val;
      end else if (val_lt(from_left.val, held_val_r)) begin
        // newcomer is strictly smaller: it stays, old value moves on
        held_val_nxt = from_left.val;
        pass_vld_nxt = 1'b1;
        pass_val_nxt = held_val_r;
      end else begin
        // ties go right so earlier items stay ahead
        pass_vld_nxt = 1'b1;
        pass_val_nxt = from_left.val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_vld_r <= 1'b0;
      pass_vld_r <= 1'b0;
    end else begin
      held_vld_r <= held_vld_nxt;
      pass_vld_r <= pass_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_val_r <= held_val_nxt;
    pass_val_r <= pass_val_nxt;
  end

  assign held     = '{vld: held_vld_r, val: held_val_r};
  assign to_right = '{vld: pass_vld_r, val: pass_val_r};

endmodule

// ===== src/merge_sort_engine_unit.sv =====
// Stable ascending sorter: a chain of MAX_ITEMS insertion cells.
// One item is accepted per cycle while loading; after the final item the
// chain settles (values ripple towards the cell at the tail), then n results
// leave at one per cycle while the sink is ready, n = stored count.
// Reset (synchronous, active low) clears the cell valid bits, count and flag.
module merge_sort_engine_unit
  import mse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mse_in_if.sink    in_ch,
  mse_out_if.source out_ch
);

  localparam logic [1:0] S_LOAD   = 2'd0;
  localparam logic [1:0] S_SETTLE = 2'd1;
  localparam logic [1:0] S_EMIT   = 2'd2;

  logic [1:0] state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  logic       drop_r, drop_nxt;

  mse_link_t  pass_w [MAX_ITEMS+1];
  mse_link_t  held_w [MAX_ITEMS+1];
  logic [MAX_ITEMS-1:0] busy_w;
  logic       in_acc, out_acc, full, shift_en;

  assign full     = (count_r == cnt_t'(MAX_ITEMS));
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign shift_en = out_acc;

  // Head of the chain takes the accepted item unless the store is full
  assign pass_w[0]         = '{vld: in_acc && !full, val: in_ch.value};
  assign held_w[MAX_ITEMS] = '{vld: 1'b0, val: '0};

  // Cell chain
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    mse_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .shift_en   (shift_en),
      .from_left  (pass_w[i]),
      .from_right (held_w[i+1]),
      .held       (held_w[i]),
      .to_right   (pass_w[i+1])
    );
    assign busy_w[i] = pass_w[i+1].vld;
  end

  // Control
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    drop_nxt  = drop_r;
    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (full) drop_nxt = 1'b1;
          else      count_nxt = count_r + cnt_t'(1);
          if (in_ch.final_item) state_nxt = S_SETTLE;
        end
      end
      S_SETTLE: begin
        if (!(|busy_w)) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_acc) begin
          count_nxt = count_r - cnt_t'(1);
          if (count_r == cnt_t'(1)) begin
            state_nxt = S_LOAD;
            drop_nxt  = 1'b0;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Ports
  assign in_ch.ready         = (state_r == S_LOAD);
  assign out_ch.valid        = (state_r == S_EMIT);
  assign out_ch.sorted_value = held_w[0].val;
  assign out_ch.final_result = (count_r == cnt_t'(1));
  assign out_ch.overflow     = drop_r;

  // Checks
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> held_w[0].vld)
    else $error("result offered from an empty head cell");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(MAX_ITEMS))
    else $error("element count beyond capacity");

  a_no_ripple_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> !(|busy_w))
    else $error("chain still moving while emitting");

  a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_ch.final_result) |=> (state_r == S_LOAD && count_r == '0 && !drop_r))
    else $error("set not closed after last result");

endmodule
